// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the life stencil block.
// Needs signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define LCAS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// cons must hold at every edge where ante holds
`define LCAS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/lcas_pkg.sv =====
// Package for the life stencil block: reset values, register codes, stage control type.
// No dependencies; used by the result interface, the stencil and the top level of the block.
package lcas_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int GRID_WIDTH_RST  = 120;
    localparam int GRID_HEIGHT_RST = 30;
    localparam int MASK_W          = 9;
    // B3/S23: survive on 2 or 3 neighbors, birth on 3
    localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
    localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int OUTQ_DEPTH = 4;

    localparam int OUT_ROW_W_DEF = $clog2(MAX_HEIGHT_DEF);
    localparam int OUT_COL_W_DEF = $clog2(MAX_WIDTH_DEF);

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_SURVIVE     = 2'd2,
        REG_BIRTH       = 2'd3
    } lcas_reg_t;

    // Control that travels with a cell from the accept stage to the window stage
    typedef struct packed {
        logic valid;      // a cell is in the stage
        logic emit;       // it completes a result
        logic first_row;  // line buffer contents are stale, read as dead
        logic col0;       // first column: window restarts
        logic alive_in;   // incoming cell state (dead past the last row)
        logic last;       // the completed result ends the generation
    } lcas_ctl_t;

endpackage

// ===== sv/lcas_in_if.sv =====
// Input channel of the life stencil block: one old-generation cell or flush per transfer.
// Depends on nothing but the valid/ready convention.
interface lcas_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic cell_alive;

    modport source (output valid, output kind, output cell_alive, input ready);
    modport sink   (input valid, input kind, input cell_alive, output ready);
endinterface

// ===== sv/lcas_out_if.sv =====
// Result channel of the life stencil block: one new-generation cell per transfer.
// Widths default from lcas_pkg.
interface lcas_out_if #(
    parameter int ROW_W = lcas_pkg::OUT_ROW_W_DEF,
    parameter int COL_W = lcas_pkg::OUT_COL_W_DEF
);
    logic             valid;
    logic             ready;
    logic             new_alive;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_generation;

    modport source (output valid, output new_alive, output out_row, output out_col,
                    output last_of_generation, input ready);
    modport sink   (input valid, input new_alive, input out_row, input out_col,
                    input last_of_generation, output ready);
endinterface

// ===== sv/lcas_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lcas_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/lcas_outq.sv =====
// Small register FIFO that holds finished results until the sink takes them.
// No dependencies.
module lcas_outq #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       out_valid,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
endmodule

// ===== sv/lcas_stencil.sv =====
// 3x3 window stage and rule stage of the life stencil block.
// Uses lcas_pkg (lcas_ctl_t, MASK_W); fed by the top level's line-buffer read stage.
module lcas_stencil #(
    parameter int ROW_W = 6,
    parameter int COL_W = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcas_pkg::lcas_ctl_t          ctl,
    input  logic [2:0]                   col3,
    input  logic [ROW_W-1:0]             row,
    input  logic [COL_W-1:0]             col,
    input  logic [lcas_pkg::MASK_W-1:0]  survive,
    input  logic [lcas_pkg::MASK_W-1:0]  birth,
    output logic                         res_valid,
    output logic                         res_alive,
    output logic [ROW_W-1:0]             res_row,
    output logic [COL_W-1:0]             res_col,
    output logic                         res_last
);
    import lcas_pkg::*;

    // window bits: [2:0] left column, [5:3] center, [8:6] right; bit 0 of a column is top
    logic [8:0]       window_reg, window_next;
    logic [8:0]       eval;
    logic             s2_valid_reg;
    logic [8:0]       s2_eval_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic             s2_last_reg;
    logic [3:0]       live;

    function automatic logic [3:0] live_count(input logic [8:0] win);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                n = n + 4'(win[i]);
            end
        end
        return n;
    endfunction

    always_comb
    begin
        if (ctl.col0)
        begin
            // previous row's last cell sees a dead column on its right
            eval        = {3'b000, window_reg[8:3]};
            window_next = {col3, 6'b000000};
        end
        else
        begin
            window_next = {col3, window_reg[8:3]};
            eval        = window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.valid)
            begin
                window_reg <= window_next;
            end
            s2_valid_reg <= ctl.valid & ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_eval_reg <= eval;
        s2_row_reg  <= row;
        s2_col_reg  <= col;
        s2_last_reg <= ctl.last;
    end

    assign live      = live_count(s2_eval_reg);
    assign res_valid = s2_valid_reg;
    assign res_alive = s2_eval_reg[4] ? survive[live] : birth[live];
    assign res_row   = s2_row_reg;
    assign res_col   = s2_col_reg;
    assign res_last  = s2_last_reg;
endmodule

// ===== sv/life_cellular_automaton_step.sv =====
// One generation of a life-like automaton (default B3/S23) on a bounded grid with dead
// borders, streamed in raster order. The block takes one cell per clock and keeps that
// rate indefinitely while the result sink keeps up. The two previous rows live in one
// 2-bit-wide line-buffer RAM of MAX_WIDTH entries; each cell reads its column in the
// accept cycle and writes it back in the next cycle, with a forwarding register covering a
// one-cell-wide grid where consecutive cells share an entry. A result is completed by the
// cell one row and one column later and passes the line-buffer and rule registers into the
// output queue; send grid_width+1 flush items after a frame to drain it. A four-entry
// output queue decouples the sink: ready drops only when that queue plus the two cells in
// flight would fill it. The line buffer needs no clearing pass after reset or at frame
// end: its contents are ignored during the first row of every frame. Registers (APB,
// byte address 4*i): grid_width, grid_height, survive_mask, birth_mask. Write them only
// while the block is idle; a geometry write restarts the frame.
`include "assert_macros.svh"

module life_cellular_automaton_step #(
    parameter int MAX_WIDTH  = lcas_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lcas_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lcas_in_if.sink                         cells,
    lcas_out_if.source                      results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcas_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lcas_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lcas_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import lcas_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);        // column index
    localparam int ROW_W = $clog2(MAX_HEIGHT);       // result row index
    localparam int GW_W  = $clog2(MAX_WIDTH + 1);    // grid_width register
    localparam int GH_W  = $clog2(MAX_HEIGHT + 1);   // grid_height register
    localparam int IR_W  = $clog2(MAX_HEIGHT + 2);   // input row runs to height+1
    localparam int Q_W   = 1 + ROW_W + COL_W + 1;
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int CR_W  = $clog2(OUTQ_DEPTH + 3);

    // ---------------- configuration ----------------
    logic [GW_W-1:0]   grid_width_reg;
    logic [GH_W-1:0]   grid_height_reg;
    logic [MASK_W-1:0] survive_reg;
    logic [MASK_W-1:0] birth_reg;
    logic              cfg_wr;
    logic              geo_wr;
    lcas_reg_t         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = lcas_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign geo_wr  = cfg_wr & ((reg_idx == REG_GRID_WIDTH) || (reg_idx == REG_GRID_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GW_W'(GRID_WIDTH_RST);
            grid_height_reg <= GH_W'(GRID_HEIGHT_RST);
            survive_reg     <= SURVIVE_RST;
            birth_reg       <= BIRTH_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[GW_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[GH_W-1:0];
                REG_SURVIVE:     survive_reg     <= pwdata[MASK_W-1:0];
                REG_BIRTH:       birth_reg       <= pwdata[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            REG_SURVIVE:     prdata = APB_DATA_W'(survive_reg);
            REG_BIRTH:       prdata = APB_DATA_W'(birth_reg);
            default:         prdata = '0;
        endcase
    end

    // geometry in use: clamped to 1..MAX
    logic [GW_W-1:0] w_eff;
    logic [GH_W-1:0] h_eff;

    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = GW_W'(1);
        else if (grid_width_reg > GW_W'(MAX_WIDTH))
            w_eff = GW_W'(MAX_WIDTH);
        else
            w_eff = grid_width_reg;

        if (grid_height_reg == '0)
            h_eff = GH_W'(1);
        else if (grid_height_reg > GH_W'(MAX_HEIGHT))
            h_eff = GH_W'(MAX_HEIGHT);
        else
            h_eff = grid_height_reg;
    end

    // ---------------- accept stage: raster counters ----------------
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [IR_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0] res_col_reg, res_col_next;
    logic [ROW_W-1:0] res_row_reg, res_row_next;

    logic accept, skip, take, cell_v, emit_a, col_end, res_col_end, res_row_end, last_a;

    assign accept = cells.valid & cells.ready;
    // a flush at the very start of a frame is dropped without effect
    assign skip   = cells.kind & (in_row_reg == '0) & (in_col_reg == '0);
    assign take   = accept & ~skip;
    // flushes and cells past the last row enter as dead
    assign cell_v = ~cells.kind & (in_row_reg < IR_W'(h_eff)) & cells.cell_alive;
    assign emit_a = (in_row_reg >= IR_W'(2)) |
                    ((in_row_reg == IR_W'(1)) & (in_col_reg != '0));

    assign col_end     = (GW_W'(in_col_reg) + GW_W'(1)) >= w_eff;
    assign res_col_end = (GW_W'(res_col_reg) + GW_W'(1)) >= w_eff;
    assign res_row_end = (GH_W'(res_row_reg) + GH_W'(1)) >= h_eff;
    assign last_a      = emit_a & res_row_end & res_col_end;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        if (geo_wr || (take && last_a))
        begin
            // frame restarts; line buffer is masked during the next first row
            in_col_next  = '0;
            in_row_next  = '0;
            res_col_next = '0;
            res_row_next = '0;
        end
        else if (take)
        begin
            if (col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IR_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit_a)
            begin
                if (res_col_end)
                begin
                    res_col_next = '0;
                    res_row_next = res_row_reg + ROW_W'(1);
                end
                else
                begin
                    res_col_next = res_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            res_col_reg <= '0;
            res_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            res_col_reg <= res_col_next;
            res_row_reg <= res_row_next;
        end
    end

    // ---------------- line-buffer read-modify-write ----------------
    // entry bit 0: row two above the input, bit 1: row just above
    lcas_ctl_t        s1_ctl_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             fwd_hit_reg;
    logic [1:0]       fwd_data_reg;
    logic [1:0]       ram_rdata, rd_raw, rd_eff, ram_wdata;
    logic [2:0]       col3;

    lcas_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_ctl_reg.valid),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (take),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // back-to-back hit on the same entry (one-column grid): RAM data is one write late
    assign rd_raw    = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign rd_eff    = s1_ctl_reg.first_row ? 2'b00 : rd_raw;
    assign ram_wdata = {s1_ctl_reg.alive_in, rd_eff[1]};
    assign col3      = {s1_ctl_reg.alive_in, rd_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg  <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_ctl_reg.valid     <= take;
            s1_ctl_reg.emit      <= emit_a;
            s1_ctl_reg.first_row <= (in_row_reg == '0);
            s1_ctl_reg.col0      <= (in_col_reg == '0);
            s1_ctl_reg.alive_in  <= cell_v;
            s1_ctl_reg.last      <= last_a;
            fwd_hit_reg          <= take & s1_ctl_reg.valid & (s1_addr_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= in_col_reg;
        s1_row_reg   <= res_row_reg;
        s1_col_reg   <= res_col_reg;
        fwd_data_reg <= ram_wdata;
    end

    // ---------------- window and rule ----------------
    logic             res_valid, res_alive, res_last;
    logic [ROW_W-1:0] res_row;
    logic [COL_W-1:0] res_col;

    lcas_stencil #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_stencil (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (s1_ctl_reg),
        .col3      (col3),
        .row       (s1_row_reg),
        .col       (s1_col_reg),
        .survive   (survive_reg),
        .birth     (birth_reg),
        .res_valid (res_valid),
        .res_alive (res_alive),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_last  (res_last)
    );

    // ---------------- output queue ----------------
    logic             q_valid, q_pop;
    logic [Q_W-1:0]   q_data;
    logic [CNT_W-1:0] q_count;
    logic [CR_W-1:0]  credit_sum;

    assign q_pop = q_valid & results.ready;

    lcas_outq #(
        .WIDTH (Q_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data ({res_alive, res_row, res_col, res_last}),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign results.valid              = q_valid;
    assign results.new_alive          = q_data[Q_W-1];
    assign results.out_row            = q_data[Q_W-2 -: ROW_W];
    assign results.out_col            = q_data[COL_W:1];
    assign results.last_of_generation = q_data[0];

    // reserve a queue slot for every result still in flight
    assign credit_sum  = CR_W'(q_count) + CR_W'(s1_ctl_reg.valid & s1_ctl_reg.emit)
                       + CR_W'(res_valid);
    assign cells.ready = credit_sum < CR_W'(OUTQ_DEPTH);

    // ---------------- assertions ----------------
    // head of the queue sits at the bottom-right cell of the grid
    logic at_corner;

    assign at_corner = (q_data[COL_W:1] == COL_W'(w_eff - GW_W'(1))) &&
                       (q_data[Q_W-2 -: ROW_W] == ROW_W'(h_eff - GH_W'(1)));

    `LCAS_ASSERT_IMPL(a_outq_no_overflow, res_valid, q_count < CNT_W'(OUTQ_DEPTH), "output queue overflow")
    `LCAS_ASSERT_IMPL(a_fwd_col0_only, fwd_hit_reg, s1_addr_reg == '0, "forward hit off column zero")
    `LCAS_ASSERT(a_in_row_bound, in_row_reg <= IR_W'(h_eff) + IR_W'(1), "input row past drain row")
    `LCAS_ASSERT_IMPL(a_last_at_corner, q_valid && q_data[0], at_corner, "last result off corner")

endmodule
